/* rtl/rotated_pose_roi_top_defines.svh */
// Assertion macros used by the checker of the rotated pose ROI block.
`ifndef ROTATED_POSE_ROI_TOP_DEFINES_SVH
`define ROTATED_POSE_ROI_TOP_DEFINES_SVH

// Condition in one cycle implies a condition in the next cycle.
`define RPR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rotated pose ROI check failed");

// Condition implies another condition in the same cycle.
`define RPR_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rotated pose ROI check failed");

`endif

/* rtl/rpr_pkg.sv */
`default_nettype none
package rpr_pkg;

    localparam int unsigned CordicSteps = 24;
    localparam int unsigned MulSteps    = 32;
    localparam logic [31:0] QuarterTurn = 32'h4000_0000;
    localparam logic [31:0] HalfTurn    = 32'h8000_0000;
    localparam logic [31:0] ThreeQuarter = 32'hC000_0000;
    localparam logic [63:0] PiQ29       = 64'd1686629713;
    localparam logic [29:0] GainQ30     = 30'd652032874;
    localparam logic [7:0]  MaxPosesReset = 8'd4;

    typedef struct packed {
        logic               frame_start;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic signed [15:0] first_key_x;
        logic signed [15:0] first_key_y;
        logic signed [15:0] second_key_x;
        logic signed [15:0] second_key_y;
    } in_t;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic        [14:0] side;
        logic signed [15:0] corner0_x;
        logic signed [15:0] corner0_y;
        logic signed [15:0] corner1_x;
        logic signed [15:0] corner1_y;
        logic signed [15:0] corner2_x;
        logic signed [15:0] corner2_y;
        logic signed [15:0] corner3_x;
        logic signed [15:0] corner3_y;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ATAN,
        ST_RINIT,
        ST_ROT,
        ST_DONE
    } state_t;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/rotated_pose_roi_top.sv */
// Rotated square ROI from one detected pose. An accepted item that is within the
// per-frame pose limit is worked on in order: 24 iterations of the atan2 CORDIC
// stage, a set-up state, the 32 serial steps of the bit-serial angle scaling
// multiplier (the 24 rotation CORDIC iterations run inside that window) and a last
// state that forms the corners and loads the result once the output register is free.
// The multiplier's serial steps and the atan2 iterations set how long an item takes.
// The next item can be taken in the cycle after the result is loaded. Items past the
// limit are dropped in the cycle they are accepted. The input stalls while an item is
// in work; the output register lets the next item start while a result waits.
`default_nettype none
module rotated_pose_roi_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire rpr_pkg::in_t in_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output rpr_pkg::out_t     out_data,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data
);
    import rpr_pkg::*;

    state_t state_reg, state_next;
    logic [7:0] max_poses_reg, pose_count_reg;
    logic [4:0] step_cnt_reg;
    logic       out_valid_reg;
    out_t       out_reg;

    logic signed [31:0] ax_reg, ay_reg;
    logic        [31:0] az_reg;
    logic               zero_reg;
    logic        [17:0] lng3_reg;
    logic        [47:0] r_reg;
    logic signed [15:0] cx_reg, cy_reg;
    logic        [14:0] side_reg;
    logic signed [49:0] rx_reg, ry_reg;
    logic signed [33:0] rz_reg;
    logic        [31:0] sa_sr_reg;
    logic        [63:0] prod_reg, mc_reg;

    logic in_accept, load_out;
    logic [7:0] cnt_eff;
    logic pass;

    // Capture arithmetic.
    logic signed [16:0] dx, dy, w, h, lng_s, sum_x, sum_y;
    logic signed [31:0] dx_ext, dy_ext;
    logic        [15:0] lng;
    logic        [17:0] lng3;
    logic        [16:0] half3;

    // CORDIC steps.
    logic signed [31:0] ash_x, ash_y, ax_next, ay_next;
    logic        [31:0] az_next, tab;
    logic signed [49:0] rsh_x, rsh_y, rx_next, ry_next;
    logic signed [33:0] rz_next;
    logic        [31:0] rot, rot_fold;
    logic               fold;
    logic        [63:0] prod_next;

    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cnt_eff = in_data.frame_start ? 8'd0 : pose_count_reg;
    assign pass    = cnt_eff < max_poses_reg;

    always_comb
    begin
        dx = 17'(in_data.second_key_x) - 17'(in_data.first_key_x);
        dy = 17'(in_data.first_key_y) - 17'(in_data.second_key_y);
        dx_ext = {{3{dx[16]}}, dx, 12'd0};
        dy_ext = {{3{dy[16]}}, dy, 12'd0};
        w = 17'(in_data.box_right) - 17'(in_data.box_left);
        h = 17'(in_data.box_bottom) - 17'(in_data.box_top);
        lng_s = (w > h) ? w : h;
        lng = lng_s[16] ? 16'd0 : lng_s[15:0];
        lng3 = 18'(lng) + {1'b0, lng, 1'b0};
        half3 = lng3[17:1];
        sum_x = 17'(in_data.box_left) + 17'(in_data.box_right);
        sum_y = 17'(in_data.box_top) + 17'(in_data.box_bottom);
    end

    always_comb
    begin
        tab   = atan_bam(step_cnt_reg);
        ash_x = ax_reg >>> step_cnt_reg;
        ash_y = ay_reg >>> step_cnt_reg;
        if (ay_reg > 0)
        begin
            ax_next = ax_reg + ash_y;
            ay_next = ay_reg - ash_x;
            az_next = az_reg + tab;
        end
        else
        begin
            ax_next = ax_reg - ash_y;
            ay_next = ay_reg + ash_x;
            az_next = az_reg - tab;
        end

        rsh_x = rx_reg >>> step_cnt_reg;
        rsh_y = ry_reg >>> step_cnt_reg;
        if (!rz_reg[33])
        begin
            rx_next = rx_reg - rsh_y;
            ry_next = ry_reg + rsh_x;
            rz_next = rz_reg - $signed({2'b00, tab});
        end
        else
        begin
            rx_next = rx_reg + rsh_y;
            ry_next = ry_reg - rsh_x;
            rz_next = rz_reg + $signed({2'b00, tab});
        end

        rot      = QuarterTurn - az_reg;
        fold     = (rot > QuarterTurn) && (rot < ThreeQuarter);
        rot_fold = fold ? rot + HalfTurn : rot;

        // The sign bit of the angle carries negative weight.
        prod_next = prod_reg;
        if (sa_sr_reg[0])
        begin
            if (step_cnt_reg == 5'(MulSteps - 1))
                prod_next = prod_reg - mc_reg;
            else
                prod_next = prod_reg + mc_reg;
        end
    end

    function automatic logic signed [15:0] corner(input logic signed [15:0] c,
                                                  input logic signed [51:0] off);
        logic signed [51:0] t;
        logic signed [19:0] v;
        begin
            t = off + 52'sd2147483648;
            v = 20'(c) + t[51:32];
            if (v > 20'sd32767)
                return 16'sh7FFF;
            else if (v < -20'sd32768)
                return 16'sh8000;
            else
                return v[15:0];
        end
    endfunction

    logic signed [51:0] c52, s52;
    out_t res;
    always_comb
    begin
        c52 = 52'(rx_reg);
        s52 = 52'(ry_reg);
        res.angle     = prod_reg[62:47];
        res.center_x  = cx_reg;
        res.center_y  = cy_reg;
        res.side      = side_reg;
        res.corner0_x = corner(cx_reg, s52 - c52);
        res.corner0_y = corner(cy_reg, -s52 - c52);
        res.corner1_x = corner(cx_reg, c52 + s52);
        res.corner1_y = corner(cy_reg, s52 - c52);
        res.corner2_x = corner(cx_reg, c52 - s52);
        res.corner2_y = corner(cy_reg, s52 + c52);
        res.corner3_x = corner(cx_reg, -c52 - s52);
        res.corner3_y = corner(cy_reg, c52 - s52);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept && pass) state_next = ST_ATAN;
            ST_ATAN:  if (step_cnt_reg == 5'(CordicSteps - 1)) state_next = ST_RINIT;
            ST_RINIT: state_next = ST_ROT;
            ST_ROT:   if (step_cnt_reg == 5'(MulSteps - 1)) state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_DONE:  load_out = !out_valid_reg || !out_stall;
            default:  in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_poses_reg  <= MaxPosesReset;
            pose_count_reg <= 8'd0;
            step_cnt_reg   <= 5'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                max_poses_reg <= cfg_data;
            if (in_accept)
                pose_count_reg <= pass ? cnt_eff + 8'd1 : cnt_eff;
            if (state_reg != state_next)
                step_cnt_reg <= 5'd0;
            else
                step_cnt_reg <= step_cnt_reg + 5'd1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            zero_reg <= (dx == 17'sd0) && (dy == 17'sd0);
            if (dx < 0)
            begin
                ax_reg <= -dx_ext;
                ay_reg <= -dy_ext;
                az_reg <= HalfTurn;
            end
            else
            begin
                ax_reg <= dx_ext;
                ay_reg <= dy_ext;
                az_reg <= 32'd0;
            end
            lng3_reg <= lng3;
            side_reg <= (half3 > 17'd32767) ? 15'h7FFF : half3[14:0];
            cx_reg   <= sum_x[16:1];
            cy_reg   <= sum_y[16:1];
        end
        if (state_reg == ST_ATAN)
        begin
            r_reg <= 48'(lng3_reg) * 48'(GainQ30);
            // Coincident keypoints keep the atan2 angle accumulator at zero.
            if (!zero_reg)
            begin
                ax_reg <= ax_next;
                ay_reg <= ay_next;
                az_reg <= az_next;
            end
        end
        if (state_reg == ST_RINIT)
        begin
            rx_reg    <= fold ? -$signed({2'b00, r_reg}) : $signed({2'b00, r_reg});
            ry_reg    <= 50'sd0;
            rz_reg    <= 34'($signed(rot_fold));
            sa_sr_reg <= rot;
            prod_reg  <= 64'd0;
            mc_reg    <= PiQ29;
        end
        if (state_reg == ST_ROT)
        begin
            if (step_cnt_reg < 5'(CordicSteps))
            begin
                rx_reg <= rx_next;
                ry_reg <= ry_next;
                rz_reg <= rz_next;
            end
            prod_reg  <= prod_next;
            mc_reg    <= {mc_reg[62:0], 1'b0};
            sa_sr_reg <= {1'b0, sa_sr_reg[31:1]};
        end
        if (load_out)
            out_reg <= res;
    end

endmodule
`default_nettype wire

/* rtl/rpr_checker.sv */
`default_nettype none
`include "rotated_pose_roi_top_defines.svh"
module rpr_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_stall,
    input wire rpr_pkg::in_t  in_data,
    input wire logic          out_valid,
    input wire logic          out_stall,
    input wire rpr_pkg::out_t out_data,
    input wire logic          cfg_valid,
    input wire logic          cfg_ready,
    input wire logic [7:0]    cfg_data
);
    import rpr_pkg::*;

    logic unused_bits;
    assign unused_bits = in_valid ^ (^in_data) ^ cfg_valid ^ (^cfg_data);

    `RPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `RPR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
    // A new result only appears once the input has been held off.
    `RPR_ASSERT_NOW(a_out_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))
    `RPR_ASSERT_NOW(a_cfg_ready, clk, rst_n, !in_stall, cfg_ready)

endmodule

bind rotated_pose_roi_top rpr_checker u_rpr_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
);
`default_nettype wire
